@@ sv/fol_pkg.sv @@
// Shared constants, types and helpers for the frequency-ordered list unit.
package fol_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_BITS  = 16;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 6;
    localparam int OUT_COUNT_W = 16;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    // ranks run from 1 up to TABLE_DEPTH, next_rank may reach TABLE_DEPTH + 1
    localparam int RANK_W = $clog2(TABLE_DEPTH + 2);

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_W-1:0]     rank;
    } t_entry;

    function automatic logic [POS_W-1:0] pos_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

    function automatic logic [OUT_COUNT_W-1:0] count_out(input logic [COUNT_BITS-1:0] cnt);
        logic [COUNT_BITS+OUT_COUNT_W-1:0] wide;
        wide = {{OUT_COUNT_W{1'b0}}, cnt};
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

@@ sv/frequency_ordered_list_unit.sv @@
// Top level of the frequency-ordered list unit: sequencer, table RAM and compare unit.
//
// Input channel: i_in_valid / o_in_stall carry one transaction of i_opcode and i_key.
// A load appends the key at the tail, an access finds the key, bumps its count and
// moves it toward the head, a dump reports every entry in table order.
// Output channel: o_out_valid / i_out_stall carry one result per transaction, or one
// per entry for a dump, with o_last high on the final result of a transaction.
// One transaction is in progress at a time; o_in_stall is high until its last result
// sits in the output register. An access reads and compares the entries in turn, then
// moves a hit entry up one position per step while it passes its neighbor, then places
// it; a dump reads and reports one entry per step. The single read port of the table
// RAM is read one entry per step, with the shared compare unit on its registered data.
// Opcode 3 is dropped and gives no result.
// Reset (synchronous, active low) empties the table, restarts ranks at one and drops
// any pending result. While the receiver stalls, the output register holds its
// result and the sequencer waits before it produces the next one.
module frequency_ordered_list_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fol_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [fol_pkg::KEY_W-1:0]    i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fol_pkg::STATUS_W-1:0]        o_status,
    output logic [fol_pkg::POS_W-1:0]           o_position,
    output logic signed [fol_pkg::KEY_W-1:0]    o_entry_key,
    output logic [fol_pkg::OUT_COUNT_W-1:0]     o_count,
    output logic                                o_last
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SRCH_RD   = 4'd1;
    localparam logic [3:0] S_SRCH_CMP  = 4'd2;
    localparam logic [3:0] S_MOVE_RD   = 4'd3;
    localparam logic [3:0] S_MOVE_CMP  = 4'd4;
    localparam logic [3:0] S_PLACE     = 4'd5;
    localparam logic [3:0] S_EMIT      = 4'd6;
    localparam logic [3:0] S_DUMP_RD   = 4'd7;
    localparam logic [3:0] S_DUMP_EMIT = 4'd8;

    localparam int EW = $bits(fol_pkg::t_entry);

    logic [3:0]                         r_state,     n_state;
    logic [fol_pkg::KEY_W-1:0]          r_key,       n_key;
    logic [fol_pkg::IDX_W-1:0]          r_idx,       n_idx;
    logic [fol_pkg::FILL_W-1:0]         r_fill,      n_fill;
    logic [fol_pkg::RANK_W-1:0]         r_next_rank, n_next_rank;
    fol_pkg::t_entry                    r_mov,       n_mov;
    logic [fol_pkg::STATUS_W-1:0]       r_res_status, n_res_status;
    logic [fol_pkg::POS_W-1:0]          r_res_pos,   n_res_pos;
    logic [fol_pkg::KEY_W-1:0]          r_res_key,   n_res_key;
    logic [fol_pkg::OUT_COUNT_W-1:0]    r_res_count, n_res_count;

    logic                               r_out_valid;
    logic [fol_pkg::STATUS_W-1:0]       r_out_status;
    logic [fol_pkg::POS_W-1:0]          r_out_pos;
    logic [fol_pkg::KEY_W-1:0]          r_out_key;
    logic [fol_pkg::OUT_COUNT_W-1:0]    r_out_count;
    logic                               r_out_last;

    logic                               out_load;
    logic [fol_pkg::STATUS_W-1:0]       out_status;
    logic [fol_pkg::POS_W-1:0]          out_pos;
    logic [fol_pkg::KEY_W-1:0]          out_key;
    logic [fol_pkg::OUT_COUNT_W-1:0]    out_count;
    logic                               out_last;
    logic                               out_free;

    logic                               wr_en;
    logic [fol_pkg::IDX_W-1:0]          wr_addr;
    fol_pkg::t_entry                    wr_data;
    logic                               rd_en;
    logic [fol_pkg::IDX_W-1:0]          rd_addr;
    logic [EW-1:0]                      rd_raw;
    fol_pkg::t_entry                    rd_data;

    logic                               cmp_order;
    logic                               cmp_match;
    logic                               idx_last;
    logic [fol_pkg::IDX_W-1:0]          idx_dec;

    fol_ram #(
        .WIDTH (EW),
        .DEPTH (fol_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_data = rd_raw;

    fol_cmp u_cmp (
        .i_order_mode (cmp_order),
        .i_slot       (rd_data),
        .i_mov        (r_mov),
        .i_key        (r_key),
        .o_match      (cmp_match)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_last = ((fol_pkg::FILL_W'(r_idx) + fol_pkg::FILL_W'(1)) == r_fill);
    assign idx_dec  = r_idx - fol_pkg::IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_idx        = r_idx;
        n_fill       = r_fill;
        n_next_rank  = r_next_rank;
        n_mov        = r_mov;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_key    = r_res_key;
        n_res_count  = r_res_count;

        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_mov;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        cmp_order = 1'b0;

        out_load   = 1'b0;
        out_status = r_res_status;
        out_pos    = r_res_pos;
        out_key    = r_res_key;
        out_count  = r_res_count;
        out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key       = i_key;
                    n_res_key   = i_key;
                    n_res_pos   = '0;
                    n_res_count = '0;
                    n_idx       = '0;
                    if (i_opcode == fol_pkg::OP_LOAD) begin
                        if (r_fill == fol_pkg::FILL_W'(fol_pkg::TABLE_DEPTH)) begin
                            n_res_status = fol_pkg::ST_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_addr       = r_fill[fol_pkg::IDX_W-1:0];
                            wr_data.key   = i_key;
                            wr_data.count = '0;
                            wr_data.rank  = '0;
                            n_fill        = r_fill + fol_pkg::FILL_W'(1);
                            n_res_status  = fol_pkg::ST_OK;
                            n_res_pos     = fol_pkg::pos_out(r_fill[fol_pkg::IDX_W-1:0]);
                        end
                        n_state = S_EMIT;
                    end else if (i_opcode == fol_pkg::OP_ACCESS) begin
                        if (r_fill == '0) begin
                            n_res_status = fol_pkg::ST_MISS;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end else if (i_opcode == fol_pkg::OP_DUMP) begin
                        if (r_fill == '0) begin
                            n_res_status = fol_pkg::ST_EMPTY;
                            n_res_key    = '0;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_DUMP_RD;
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                rd_en   = 1'b1;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (cmp_match) begin
                    n_mov = rd_data;
                    if (rd_data.count != {fol_pkg::COUNT_BITS{1'b1}}) begin
                        n_mov.count = rd_data.count + fol_pkg::COUNT_BITS'(1);
                    end
                    if (rd_data.rank == '0) begin
                        n_mov.rank  = r_next_rank;
                        n_next_rank = r_next_rank + fol_pkg::RANK_W'(1);
                    end
                    n_state = (r_idx == '0) ? S_PLACE : S_MOVE_RD;
                end else if (idx_last) begin
                    n_res_status = fol_pkg::ST_MISS;
                    n_state      = S_EMIT;
                end else begin
                    n_idx   = r_idx + fol_pkg::IDX_W'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_MOVE_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_dec;
                n_state = S_MOVE_CMP;
            end
            S_MOVE_CMP: begin
                cmp_order = 1'b1;
                if (cmp_match) begin
                    // shift the neighbor down one place, keep climbing
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_idx   = idx_dec;
                    n_state = (idx_dec == '0) ? S_PLACE : S_MOVE_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                wr_en        = 1'b1;
                n_res_status = fol_pkg::ST_OK;
                n_res_pos    = fol_pkg::pos_out(r_idx);
                n_res_key    = r_mov.key;
                n_res_count  = fol_pkg::count_out(r_mov.count);
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                rd_en   = 1'b1;
                n_state = S_DUMP_EMIT;
            end
            S_DUMP_EMIT: begin
                out_status = fol_pkg::ST_OK;
                out_pos    = fol_pkg::pos_out(r_idx);
                out_key    = rd_data.key;
                out_count  = fol_pkg::count_out(rd_data.count);
                out_last   = idx_last;
                if (out_free) begin
                    out_load = 1'b1;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + fol_pkg::IDX_W'(1);
                        n_state = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_next_rank <= fol_pkg::RANK_W'(1);
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_next_rank <= n_next_rank;
            r_idx       <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_mov        <= n_mov;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_key    <= n_res_key;
        r_res_count  <= n_res_count;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_pos    <= out_pos;
            r_out_key    <= out_key;
            r_out_count  <= out_count;
            r_out_last   <= out_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_position  = r_out_pos;
    assign o_entry_key = r_out_key;
    assign o_count     = r_out_count;
    assign o_last      = r_out_last;

endmodule

@@ sv/fol_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data when no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/fol_cmp.sv @@
// Shared compare unit: key match during search, ordering test during the move.
module fol_cmp (
    input  logic                      i_order_mode,
    input  fol_pkg::t_entry           i_slot,
    input  fol_pkg::t_entry           i_mov,
    input  logic [fol_pkg::KEY_W-1:0] i_key,
    output logic                      o_match
);

    logic key_eq;
    logic mov_ahead;

    assign key_eq = (i_slot.key == i_key);

    // moving entry passes a neighbor with lower count, or equal count and later rank
    assign mov_ahead = (i_slot.count < i_mov.count) ||
                       ((i_slot.count == i_mov.count) && (i_slot.rank > i_mov.rank));

    assign o_match = i_order_mode ? mov_ahead : key_eq;

endmodule
